[design/rcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types and constants for the rectangle / circle fill rasterizer.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int COORD_BITS  = 12;
  localparam int COORD_LIMIT = 1 << COORD_BITS;
  localparam int DIM_BITS    = 13;
  localparam int PITCH_BITS  = 16;
  localparam int BPP_BITS    = 6;
  localparam int BPB_BITS    = BPP_BITS - 3;
  localparam int BASE_BITS   = 30;
  localparam int ADDR_BITS   = 31;
  localparam int DATA_BITS   = 32;
  localparam int CFG_IDX_BITS = 3;
  // signed box arithmetic: holds frame dims and px + size
  localparam int XW = (COORD_BITS + 2 > DIM_BITS + 1) ? COORD_BITS + 2 : DIM_BITS + 1;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [DIM_BITS-1:0]   FRAME_WIDTH_RST  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0]   FRAME_HEIGHT_RST = DIM_BITS'(480);
  localparam logic [PITCH_BITS-1:0] LINE_PITCH_RST   = PITCH_BITS'(2560);
  localparam logic [BPP_BITS-1:0]   BPP_RST          = BPP_BITS'(32);
  localparam logic [DATA_BITS-1:0]  BUFFER_BASE_RST  = '0;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [COORD_BITS:0]   delta_t;
  typedef logic signed [XW-1:0]         sx_t;

  typedef enum logic [1:0] {
    OP_RECT = 2'd0,
    OP_CIRC = 2'd1,
    OP_STEP = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RECT = 2'd1,
    MODE_CIRC = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LINE_PITCH   = 3'd2,
    REG_BPP          = 3'd3,
    REG_BUFFER_BASE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]           operation;
    coord_t               pos_x;
    coord_t               pos_y;
    coord_t               size_a;
    coord_t               size_b;
    logic [DATA_BITS-1:0] fill_color;
  } in_item_t;

  typedef struct packed {
    logic                 write_enable;
    logic [ADDR_BITS-1:0] byte_address;
    logic [DATA_BITS-1:0] pixel_word;
    logic                 shape_done;
  } out_item_t;

  // one classified transaction on its way from front to back
  typedef struct packed {
    logic                 is_step;
    logic                 is_circ;
    logic                 done;
    delta_t               dx;
    delta_t               dy;
    coord_t               radius;
    coord_t               row;
    coord_t               col;
    logic [DATA_BITS-1:0] color;
  } job_t;

  typedef struct packed {
    logic [PITCH_BITS-1:0] line_pitch;
    logic [BPB_BITS-1:0]   pix_bytes;
    logic [BASE_BITS-1:0]  buffer_base;
  } addr_cfg_t;

endpackage

[design/rect_circle_fill_rasterizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_circle_fill_rasterizer_unit
// Rectangle and filled-circle fill engine producing framebuffer pixel writes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | in_item_t: command or step
//  out_    | output    | out_valid / out_stall | out_item_t: one pixel result
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One transaction per clock in and out while neither side stalls; each input gives exactly one result.
//  Each job passes through the job queue, the product stage and the output register.
//  The scan walk in the front end advances one position per accepted step.
//  Reset is synchronous; no clearing pass, the block is ready right after it.
//  out_stall holds the back pipeline; the queue absorbs QUEUE_DEPTH
//  transactions before in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
module rect_circle_fill_rasterizer_unit #(
  parameter int QUEUE_DEPTH = rcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rcf_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rcf_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rcf_pkg::DATA_BITS-1:0]     cfg_data
);
  import rcf_pkg::*;

  job_t      push_job, head_job;
  logic      q_push, q_pop, q_full, q_empty;
  addr_cfg_t addr_cfg;

  rcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .addr_cfg  (addr_cfg)
  );

  rcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  rcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (head_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .addr_cfg  (addr_cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[design/rcf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_front
// Command front end: config registers, shape clipping and scan walk.
// Every accepted transaction is turned into one job for the back end.
// ----------------------------------------------------------------------------
module rcf_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  rcf_pkg::in_item_t                  in_data,
  output logic                               in_stall,
  input  logic                               q_full,
  output logic                               q_push,
  output rcf_pkg::job_t                      q_job,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rcf_pkg::DATA_BITS-1:0]      cfg_data,
  output rcf_pkg::addr_cfg_t                 addr_cfg
);
  import rcf_pkg::*;

  localparam sx_t LIMIT_S = sx_t'(COORD_LIMIT);
  localparam sx_t ONE_S   = sx_t'(1);
  localparam sx_t ZERO_S  = '0;

  logic [DIM_BITS-1:0]   frame_width_r, frame_height_r;
  logic [PITCH_BITS-1:0] line_pitch_r;
  logic [BPP_BITS-1:0]   bpp_r;
  logic [DATA_BITS-1:0]  buffer_base_r;

  mode_t  mode_r, mode_nxt;
  coord_t scan_col_r, scan_col_nxt;
  coord_t scan_row_r, scan_row_nxt;
  coord_t first_col_r, first_col_nxt;
  coord_t last_col_r, last_col_nxt;
  coord_t last_row_r, last_row_nxt;
  coord_t center_col_r, center_col_nxt;
  coord_t center_row_r, center_row_nxt;
  coord_t radius_r, radius_nxt;
  logic [DATA_BITS-1:0] color_r, color_nxt;

  op_t  op;
  sx_t  lim_x, lim_y, x0, x1, y0, y1, x0c, x1c, y0c, y1c;
  logic box_ok;
  logic at_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign op        = op_t'(in_data.operation);
  assign at_end    = (scan_col_r == last_col_r) && (scan_row_r == last_row_r);

  assign addr_cfg.line_pitch  = line_pitch_r;
  assign addr_cfg.pix_bytes   = bpp_r[BPP_BITS-1:3];
  assign addr_cfg.buffer_base = buffer_base_r[BASE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      line_pitch_r   <= LINE_PITCH_RST;
      bpp_r          <= BPP_RST;
      buffer_base_r  <= BUFFER_BASE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_BITS-1:0];
        REG_LINE_PITCH:   line_pitch_r   <= cfg_data[PITCH_BITS-1:0];
        REG_BPP:          bpp_r          <= cfg_data[BPP_BITS-1:0];
        REG_BUFFER_BASE:  buffer_base_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // bounding box, clipped to the (saturated) frame
  always_comb begin
    lim_x = (sx_t'(frame_width_r) > LIMIT_S) ? LIMIT_S : sx_t'(frame_width_r);
    lim_y = (sx_t'(frame_height_r) > LIMIT_S) ? LIMIT_S : sx_t'(frame_height_r);
    if (op == OP_CIRC) begin
      x0 = sx_t'(in_data.pos_x) - sx_t'(in_data.size_a);
      x1 = sx_t'(in_data.pos_x) + sx_t'(in_data.size_a);
      y0 = sx_t'(in_data.pos_y) - sx_t'(in_data.size_a);
      y1 = sx_t'(in_data.pos_y) + sx_t'(in_data.size_a);
    end else begin
      x0 = sx_t'(in_data.pos_x);
      x1 = sx_t'(in_data.pos_x) + sx_t'(in_data.size_b) - ONE_S;
      y0 = sx_t'(in_data.pos_y);
      y1 = sx_t'(in_data.pos_y) + sx_t'(in_data.size_a) - ONE_S;
    end
    x0c = (x0 < ZERO_S) ? ZERO_S : x0;
    y0c = (y0 < ZERO_S) ? ZERO_S : y0;
    x1c = (x1 > lim_x - ONE_S) ? lim_x - ONE_S : x1;
    y1c = (y1 > lim_y - ONE_S) ? lim_y - ONE_S : y1;
    box_ok = (op == OP_CIRC || (in_data.size_a != '0 && in_data.size_b != '0)) &&
             (x0c <= x1c) && (y0c <= y1c);
  end

  // next state
  always_comb begin
    mode_nxt       = mode_r;
    scan_col_nxt   = scan_col_r;
    scan_row_nxt   = scan_row_r;
    first_col_nxt  = first_col_r;
    last_col_nxt   = last_col_r;
    last_row_nxt   = last_row_r;
    center_col_nxt = center_col_r;
    center_row_nxt = center_row_r;
    radius_nxt     = radius_r;
    color_nxt      = color_r;
    if (q_push) begin
      unique case (op)
        OP_RECT, OP_CIRC: begin
          color_nxt      = in_data.fill_color;
          center_col_nxt = in_data.pos_x;
          center_row_nxt = in_data.pos_y;
          radius_nxt     = in_data.size_a;
          if (box_ok) begin
            mode_nxt      = (op == OP_CIRC) ? MODE_CIRC : MODE_RECT;
            first_col_nxt = x0c[COORD_BITS-1:0];
            scan_col_nxt  = x0c[COORD_BITS-1:0];
            scan_row_nxt  = y0c[COORD_BITS-1:0];
            last_col_nxt  = x1c[COORD_BITS-1:0];
            last_row_nxt  = y1c[COORD_BITS-1:0];
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        OP_STEP: begin
          if (mode_r != MODE_IDLE) begin
            if (scan_col_r == last_col_r) begin
              if (scan_row_r == last_row_r) begin
                mode_nxt = MODE_IDLE;
              end else begin
                scan_row_nxt = scan_row_r + 1'b1;
                scan_col_nxt = first_col_r;
              end
            end else begin
              scan_col_nxt = scan_col_r + 1'b1;
            end
          end
        end
        OP_NONE: ;
      endcase
    end
  end

  // job for the back end
  always_comb begin
    q_job = '0;
    unique case (op)
      OP_RECT, OP_CIRC: q_job.done = !box_ok;
      OP_STEP: begin
        if (mode_r == MODE_IDLE) begin
          q_job.done = 1'b1;
        end else begin
          q_job.is_step = 1'b1;
          q_job.is_circ = (mode_r == MODE_CIRC);
          q_job.done    = at_end;
          q_job.dx      = signed'({1'b0, scan_col_r}) - signed'({1'b0, center_col_r});
          q_job.dy      = signed'({1'b0, scan_row_r}) - signed'({1'b0, center_row_r});
          q_job.radius  = radius_r;
          q_job.row     = scan_row_r;
          q_job.col     = scan_col_r;
          q_job.color   = color_r;
        end
      end
      OP_NONE: q_job.done = (mode_r == MODE_IDLE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      scan_col_r   <= '0;
      scan_row_r   <= '0;
      first_col_r  <= '0;
      last_col_r   <= '0;
      last_row_r   <= '0;
      center_col_r <= '0;
      center_row_r <= '0;
      radius_r     <= '0;
      color_r      <= '0;
    end else begin
      mode_r       <= mode_nxt;
      scan_col_r   <= scan_col_nxt;
      scan_row_r   <= scan_row_nxt;
      first_col_r  <= first_col_nxt;
      last_col_r   <= last_col_nxt;
      last_row_r   <= last_row_nxt;
      center_col_r <= center_col_nxt;
      center_row_r <= center_row_nxt;
      radius_r     <= radius_nxt;
      color_r      <= color_nxt;
    end
  end

endmodule

[design/rcf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_queue
// Small FIFO of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module rcf_queue #(
  parameter int DEPTH = rcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rcf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output rcf_pkg::job_t head_job,
  output logic          empty
);
  import rcf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[design/rcf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_back
// Two-stage pixel pipeline: products, then circle test and address sum
// into the output register.
// ----------------------------------------------------------------------------
module rcf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rcf_pkg::job_t       q_job,
  input  logic                q_empty,
  output logic                q_pop,
  input  rcf_pkg::addr_cfg_t  addr_cfg,
  output logic                out_valid,
  input  logic                out_stall,
  output rcf_pkg::out_item_t  out_data
);
  import rcf_pkg::*;

  localparam int SQW  = 2 * COORD_BITS;
  localparam int ROWW = COORD_BITS + PITCH_BITS;
  localparam int COLW = COORD_BITS + BPB_BITS;
  localparam int AW   = ((ROWW > BASE_BITS) ? ROWW : BASE_BITS) + 2;

  logic en;

  // stage 1
  logic                 s1_valid_r;
  logic                 s1_is_step_r, s1_is_circ_r, s1_done_r;
  logic [SQW-1:0]       s1_dx2_r, s1_dy2_r, s1_r2_r;
  logic [ROWW-1:0]      s1_rowp_r;
  logic [COLW-1:0]      s1_colb_r;
  logic [DATA_BITS-1:0] s1_color_r;

  logic signed [SQW+1:0] dx_sq, dy_sq;
  logic [SQW-1:0]        r_sq;
  logic [ROWW-1:0]       rowp;
  logic [COLW-1:0]       colb;

  // output stage
  logic       out_valid_r;
  out_item_t  out_item_r, out_item_nxt;
  logic [SQW:0]    dist_sq;
  logic            in_circle;
  logic [AW-1:0]   addr_sum;

  assign en        = !out_valid_r || !out_stall;
  assign q_pop     = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    dx_sq = (SQW+2)'(q_job.dx) * (SQW+2)'(q_job.dx);
    dy_sq = (SQW+2)'(q_job.dy) * (SQW+2)'(q_job.dy);
    r_sq  = SQW'(q_job.radius) * SQW'(q_job.radius);
    rowp  = ROWW'(q_job.row) * ROWW'(addr_cfg.line_pitch);
    colb  = COLW'(q_job.col) * COLW'(addr_cfg.pix_bytes);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_is_step_r <= q_job.is_step;
      s1_is_circ_r <= q_job.is_circ;
      s1_done_r    <= q_job.done;
      s1_dx2_r     <= dx_sq[SQW-1:0];
      s1_dy2_r     <= dy_sq[SQW-1:0];
      s1_r2_r      <= r_sq;
      s1_rowp_r    <= rowp;
      s1_colb_r    <= colb;
      s1_color_r   <= q_job.color;
    end
  end

  always_comb begin
    dist_sq   = {1'b0, s1_dx2_r} + {1'b0, s1_dy2_r};
    in_circle = !s1_is_circ_r || (dist_sq <= {1'b0, s1_r2_r});
    addr_sum  = AW'(addr_cfg.buffer_base) + AW'(s1_rowp_r) + AW'(s1_colb_r);
    out_item_nxt = '0;
    out_item_nxt.shape_done = s1_done_r;
    if (s1_is_step_r && in_circle) begin
      out_item_nxt.write_enable = 1'b1;
      out_item_nxt.byte_address = addr_sum[ADDR_BITS-1:0];
      // rotate right by one byte, MSB first: R,G,B,A -> A,R,G,B
      out_item_nxt.pixel_word   = {s1_color_r[7:0], s1_color_r[DATA_BITS-1:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

[design/rcf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_checker
// Port-level assertions for the fill rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module rcf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input rcf_pkg::out_item_t                out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [rcf_pkg::CFG_IDX_BITS-1:0]  cfg_index
);
  import rcf_pkg::*;

  logic [15:0] pending_r;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result without an outstanding transaction");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_enable |->
      out_data.byte_address == '0 && out_data.pixel_word == '0)
    else $error("non-write result carries address or data");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == REG_BUFFER_BASE |-> cfg_ready)
    else $error("config write refused");

endmodule

bind rect_circle_fill_rasterizer_unit rcf_checker u_rcf_checker (.*);

[sim/tb_rect_circle_fill_rasterizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_circle_fill_rasterizer_unit
// Self-checking bench for the rectangle / circle fill engine. A behavioral
// copy of the scan walk predicts every pixel result from the accepted
// commands and the current register values. A monitor compares each output
// transaction with the oldest prediction. Directed cases cover clipping,
// empty shapes and register extremes. A random part follows, with mostly
// complete shapes, some cut short, and gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_rect_circle_fill_rasterizer_unit;
  import rcf_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 900;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  in_item_t                in_data;
  logic                    out_valid;
  logic                    out_stall;
  out_item_t               out_data;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [DATA_BITS-1:0]    cfg_data;

  rect_circle_fill_rasterizer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copy, updated on each accepted config transaction
  logic [DIM_BITS-1:0]   cfg_fw    = FRAME_WIDTH_RST;
  logic [DIM_BITS-1:0]   cfg_fh    = FRAME_HEIGHT_RST;
  logic [PITCH_BITS-1:0] cfg_pitch = LINE_PITCH_RST;
  logic [BPP_BITS-1:0]   cfg_bpp   = BPP_RST;
  logic [DATA_BITS-1:0]  cfg_base  = BUFFER_BASE_RST;

  // scan walk state of the predictor
  mode_t                 pm_mode     = MODE_IDLE;
  coord_t                pm_col      = '0;
  coord_t                pm_row      = '0;
  coord_t                pm_first    = '0;
  coord_t                pm_last_col = '0;
  coord_t                pm_last_row = '0;
  coord_t                pm_cx       = '0;
  coord_t                pm_cy       = '0;
  coord_t                pm_rad      = '0;
  logic [DATA_BITS-1:0]  pm_color    = '0;

  out_item_t expected_pixels[$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        cycle_count = 0;
  bit        no_gaps = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  // bounding box of a start command, clipped to the frame
  function automatic bit clip_box(input in_item_t it, output int x0, output int x1,
                                  output int y0, output int y1);
    int lx;
    int ly;
    lx = (int'(cfg_fw) > COORD_LIMIT) ? COORD_LIMIT : int'(cfg_fw);
    ly = (int'(cfg_fh) > COORD_LIMIT) ? COORD_LIMIT : int'(cfg_fh);
    if (it.operation == OP_RECT) begin
      if (it.size_a == '0 || it.size_b == '0) return 1'b0;
      x0 = int'(it.pos_x);
      x1 = x0 + int'(it.size_b) - 1;
      y0 = int'(it.pos_y);
      y1 = y0 + int'(it.size_a) - 1;
    end else begin
      x0 = int'(it.pos_x) - int'(it.size_a);
      x1 = int'(it.pos_x) + int'(it.size_a);
      y0 = int'(it.pos_y) - int'(it.size_a);
      y1 = int'(it.pos_y) + int'(it.size_a);
    end
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > lx - 1) x1 = lx - 1;
    if (y1 > ly - 1) y1 = ly - 1;
    return (x0 <= x1) && (y0 <= y1);
  endfunction

  function automatic out_item_t predict_pixel(input in_item_t it);
    out_item_t         res;
    int                x0;
    int                x1;
    int                y0;
    int                y1;
    longint            dx;
    longint            dy;
    longint            r;
    longint unsigned   a;
    bit                hit;
    res = '0;
    case (it.operation)
      OP_RECT, OP_CIRC: begin
        pm_color = it.fill_color;
        pm_cx    = it.pos_x;
        pm_cy    = it.pos_y;
        pm_rad   = it.size_a;
        if (clip_box(it, x0, x1, y0, y1)) begin
          if (it.operation == OP_RECT) pm_mode = MODE_RECT;
          else pm_mode = MODE_CIRC;
          pm_first    = coord_t'(x0);
          pm_col      = coord_t'(x0);
          pm_row      = coord_t'(y0);
          pm_last_col = coord_t'(x1);
          pm_last_row = coord_t'(y1);
        end else begin
          pm_mode = MODE_IDLE;
          res.shape_done = 1'b1;
        end
      end
      OP_STEP: begin
        if (pm_mode == MODE_IDLE) begin
          res.shape_done = 1'b1;
        end else begin
          hit = 1'b1;
          if (pm_mode == MODE_CIRC) begin
            dx  = longint'(pm_col) - longint'(pm_cx);
            dy  = longint'(pm_row) - longint'(pm_cy);
            r   = longint'(pm_rad);
            hit = (dx * dx + dy * dy) <= r * r;
          end
          if (hit) begin
            a = longint'(cfg_base & 32'h3FFF_FFFF)
              + longint'(pm_row) * longint'(cfg_pitch)
              + longint'(pm_col) * longint'(cfg_bpp >> 3);
            res.write_enable = 1'b1;
            res.byte_address = a[ADDR_BITS-1:0];
            res.pixel_word   = {pm_color[7:0], pm_color[31:8]};
          end
          if (pm_col == pm_last_col) begin
            if (pm_row == pm_last_row) begin
              res.shape_done = 1'b1;
              pm_mode = MODE_IDLE;
            end else begin
              pm_row = pm_row + 1'b1;
              pm_col = pm_first;
            end
          end else begin
            pm_col = pm_col + 1'b1;
          end
        end
      end
      default: res.shape_done = (pm_mode == MODE_IDLE);
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // monitor: register writes, accepted commands, result check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  cfg_fw    = cfg_data[DIM_BITS-1:0];
          REG_FRAME_HEIGHT: cfg_fh    = cfg_data[DIM_BITS-1:0];
          REG_LINE_PITCH:   cfg_pitch = cfg_data[PITCH_BITS-1:0];
          REG_BPP:          cfg_bpp   = cfg_data[BPP_BITS-1:0];
          REG_BUFFER_BASE:  cfg_base  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_pixels.push_back(predict_pixel(in_data));
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with nothing pending");
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0d, got %0d",
                   want.write_enable, out_data.write_enable);
            mismatch_count++;
          end
          if (out_data.byte_address !== want.byte_address) begin
            $error("byte_address: expected %h, got %h",
                   want.byte_address, out_data.byte_address);
            mismatch_count++;
          end
          if (out_data.pixel_word !== want.pixel_word) begin
            $error("pixel_word: expected %h, got %h", want.pixel_word, out_data.pixel_word);
            mismatch_count++;
          end
          if (out_data.shape_done !== want.shape_done) begin
            $error("shape_done: expected %0d, got %0d", want.shape_done, out_data.shape_done);
            mismatch_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // mostly short, now and then long
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  initial begin : out_stall_driver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  end

  function automatic in_item_t rand_payload(input op_t op);
    in_item_t it;
    it.operation  = op;
    it.pos_x      = coord_t'($urandom);
    it.pos_y      = coord_t'($urandom);
    it.size_a     = coord_t'($urandom);
    it.size_b     = coord_t'($urandom);
    it.fill_color = $urandom;
    return it;
  endfunction

  function automatic in_item_t shape_cmd(input op_t op, input coord_t x, input coord_t y,
                                         input coord_t a, input coord_t b,
                                         input logic [DATA_BITS-1:0] color);
    in_item_t it;
    it.operation  = op;
    it.pos_x      = x;
    it.pos_y      = y;
    it.size_a     = a;
    it.size_b     = b;
    it.fill_color = color;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int n;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (it.operation != OP_NONE) items_sent++;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_steps(input int n);
    repeat (n) send_item(rand_payload(OP_STEP));
  endtask

  // start a shape, then walk up to cap positions of its box and extra more
  task automatic draw_shape(input in_item_t cmd, input int cap, input int extra);
    int x0;
    int x1;
    int y0;
    int y1;
    int n;
    send_item(cmd);
    n = 0;
    if (clip_box(cmd, x0, x1, y0, y1)) n = (x1 - x0 + 1) * (y1 - y0 + 1);
    if (n > cap) n = cap;
    send_steps(n + extra);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [31:0] fw, input logic [31:0] fh,
                            input logic [31:0] pitch, input logic [31:0] bpp,
                            input logic [31:0] base);
    wait_drain();
    put_reg(REG_FRAME_WIDTH, fw);
    put_reg(REG_FRAME_HEIGHT, fh);
    put_reg(REG_LINE_PITCH, pitch);
    put_reg(REG_BPP, bpp);
    put_reg(REG_BUFFER_BASE, base);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 8);
      1:       return 32'd640;
      2:       return COORD_LIMIT;
      3:       return $urandom_range(COORD_LIMIT + 1, 8191);
      4:       return $urandom_range(0, 8191);
      default: return $urandom_range(9, 64);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_idle_and_defaults();
    send_item(rand_payload(OP_STEP));
    send_item(rand_payload(OP_NONE));
    draw_shape(shape_cmd(OP_RECT, 12'd0, 12'd0, 12'd1, 12'd2, 32'hFFFF_FFFF), 1000, 1);
    // far corner, oversized: clipped to one pixel
    draw_shape(shape_cmd(OP_RECT, 12'd639, 12'd479, 12'hFFF, 12'hFFF, 32'h1234_5678),
               1000, 0);
  endtask

  task automatic test_zero_and_edges();
    draw_shape(shape_cmd(OP_RECT, 12'd10, 12'd10, 12'd0, 12'd5, 32'h0102_0304), 1000, 0);
    draw_shape(shape_cmd(OP_RECT, 12'd10, 12'd10, 12'd5, 12'd0, 32'h0506_0708), 1000, 0);
    draw_shape(shape_cmd(OP_CIRC, 12'd3, 12'd3, 12'd0, 12'd0, 32'h0000_00FF), 1000, 0);
    // circle clipped at left and top
    draw_shape(shape_cmd(OP_CIRC, 12'd0, 12'd0, 12'd1, 12'hFFF, 32'hA5A5_5A5A), 1000, 0);
    // huge circle, op three while busy, then dropped by an empty start
    send_item(shape_cmd(OP_CIRC, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 32'h0));
    send_item(rand_payload(OP_NONE));
    send_steps(1);
    draw_shape(shape_cmd(OP_RECT, 12'hFFF, 12'd0, 12'd1, 12'd1, 32'hDEAD_BEEF), 1000, 0);
  endtask

  task automatic test_frame_limits();
    set_config(32'd8191, COORD_LIMIT, 32'hFFFF, 32'd63, 32'hFFFF_FFFF);
    draw_shape(shape_cmd(OP_RECT, 12'hFFF, 12'hFFF, 12'd2, 12'd2, 32'hC3C3_3C3C), 1000, 0);
    set_config(32'd0, 32'd480, 32'd0, 32'd0, 32'd0);
    draw_shape(shape_cmd(OP_RECT, 12'd0, 12'd0, 12'd1, 12'd1, 32'h1111_2222), 1000, 0);
    set_config(32'd1, 32'd1, 32'd1, 32'd8, 32'h4000_0000);
    draw_shape(shape_cmd(OP_CIRC, 12'd0, 12'd0, 12'd5, 12'd0, 32'h8765_4321), 1000, 0);
  endtask

  // box stays latched, address registers apply to the rest of the walk
  task automatic test_config_mid_shape();
    set_config(32'd16, 32'd16, 32'd64, 32'd16, 32'h100);
    draw_shape(shape_cmd(OP_RECT, 12'd2, 12'd2, 12'd2, 12'd2, 32'h00FF_00FF), 2, 0);
    set_config(32'd3, 32'd3, 32'd128, 32'd24, 32'hC000_0004);
    send_steps(3);
  endtask

  task automatic test_random_fill();
    int          goal;
    int          phase_end;
    int          phase;
    int          fwc;
    int          fhc;
    int          sel;
    int          cap;
    int          extra;
    int          t;
    logic [31:0] fw;
    logic [31:0] fh;
    logic [31:0] pitch;
    logic [31:0] bpp;
    in_item_t    cmd;
    goal  = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      fw = pick_dim();
      fh = pick_dim();
      if ($urandom_range(0, 3) == 0) pitch = $urandom_range(0, 1) ? 32'hFFFF : 32'h0;
      else pitch = $urandom_range(0, 32'hFFFF);
      case ($urandom_range(0, 4))
        0:       bpp = 32'd8;
        1:       bpp = 32'd16;
        2:       bpp = 32'd24;
        3:       bpp = 32'd32;
        default: bpp = $urandom_range(0, 63);
      endcase
      set_config(fw, fh, pitch, bpp, $urandom);
      no_gaps = (phase == 3);
      fwc = (fw > COORD_LIMIT) ? COORD_LIMIT : int'(fw);
      fhc = (fh > COORD_LIMIT) ? COORD_LIMIT : int'(fh);
      phase_end = items_sent + 110;
      while (items_sent < phase_end && items_sent < goal) begin
        if ($urandom_range(0, 7) == 0) send_item(rand_payload(OP_NONE));
        if ($urandom_range(0, 9) == 0) send_steps(1);
        if ($urandom_range(0, 24) == 0) wait_drain();
        if ($urandom_range(0, 1) == 1) cmd = rand_payload(OP_CIRC);
        else cmd = rand_payload(OP_RECT);
        cmd.size_a = coord_t'($urandom_range(0, 4));
        cmd.size_b = coord_t'($urandom_range(0, 7));
        cap = 1000;
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
          cmd.pos_x = (fwc > 0) ? coord_t'($urandom_range(0, fwc - 1)) : '0;
          cmd.pos_y = (fhc > 0) ? coord_t'($urandom_range(0, fhc - 1)) : '0;
        end else if (sel == 6) begin
          cmd.pos_x = coord_t'($urandom_range(0, 2));
          cmd.pos_y = coord_t'($urandom_range(0, 2));
        end else begin
          // oversized shapes near the far edges or anywhere, walked only partly
          if (sel == 7) begin
            t = fwc - int'($urandom_range(1, 3));
            cmd.pos_x = coord_t'((t < 0) ? 0 : t);
            t = fhc - int'($urandom_range(1, 3));
            cmd.pos_y = coord_t'((t < 0) ? 0 : t);
          end
          cmd.size_a = coord_t'($urandom);
          cmd.size_b = coord_t'($urandom);
          cap = $urandom_range(0, 12);
        end
        if (sel <= 6 && $urandom_range(0, 5) == 0) cap = $urandom_range(0, 6);
        extra = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 2)) : 0;
        draw_shape(cmd, cap, extra);
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // run control
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_and_defaults();
    test_zero_and_edges();
    test_frame_limits();
    test_config_mid_shape();
    test_random_fill();

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rcf_pkg.sv
design/rcf_front.sv
design/rcf_queue.sv
design/rcf_back.sv
design/rect_circle_fill_rasterizer_unit.sv
design/rcf_checker.sv
sim/tb_rect_circle_fill_rasterizer_unit.sv
